/* hw/rtl/gf48_pkg.sv */
// ----------------------------------------------------------------------------
// gf48_pkg: shared types and constants of the GF(2^48) arithmetic unit
// Field width, derived counter widths, operation codes and the beat formats
// of the request and response channels.
// ----------------------------------------------------------------------------
package gf48_pkg;

   localparam int FIELD_BITS   = 48;
   localparam int POLY_W       = FIELD_BITS + 1;
   localparam int CNT_W        = $clog2(FIELD_BITS + 1);
   localparam int LEN_W        = $clog2(FIELD_BITS + 2);
   localparam int IDX_W        = $clog2(POLY_W);
   localparam int EUCLID_LIMIT = 4 * (FIELD_BITS + 2);
   localparam int ITER_W       = $clog2(EUCLID_LIMIT + 1);

   // Reset value of the field polynomial: x^48 + 1.
   localparam logic [POLY_W-1:0] POLY_RESET = {1'b1, {(FIELD_BITS-1){1'b0}}, 1'b1};

   localparam logic [2:0] OP_ADD = 3'd0;
   localparam logic [2:0] OP_MUL = 3'd1;
   localparam logic [2:0] OP_INV = 3'd2;
   localparam logic [2:0] OP_POW = 3'd3;
   localparam logic [2:0] OP_SQR = 3'd4;

   typedef struct packed {
      logic [2:0]            operation;
      logic [FIELD_BITS-1:0] operand_a;
      logic [FIELD_BITS-1:0] operand_b;
      logic [FIELD_BITS-1:0] exponent;
   } gf48_req_type;

   typedef struct packed {
      logic [FIELD_BITS-1:0] result;
      logic                  div_by_zero;
   } gf48_rsp_type;

endpackage

/* hw/rtl/gf2_48_arithmetic_unit.sv */
// ----------------------------------------------------------------------------
// gf2_48_arithmetic_unit: GF(2^48) arithmetic unit
// Add, multiply, inverse, power and repeated squaring over a programmable
// degree-48 field polynomial, one request beat in and one response beat out.
// ----------------------------------------------------------------------------
// Operations: add and unused codes finish in the sequencer alone; multiply is
// one pass of the bit-serial multiplier; power does 48 squarings plus one
// multiply per set exponent bit; repeated squaring reduces the exponent mod
// 48, then squares that many times; inverse takes up to 200 Euclid steps.
// One beat is in work at a time: a new request is taken only in IDLE.
// Reset: synchronous, active high; polynomial returns to x^48 + 1.
// ----------------------------------------------------------------------------
module gf2_48_arithmetic_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  gf48_pkg::gf48_req_type        req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output gf48_pkg::gf48_rsp_type        rsp_data,
   input  logic                          csr_wr_en,
   input  logic [gf48_pkg::POLY_W-1:0]   csr_wr_data
);
   import gf48_pkg::*;

   // The sequencer walks one request through the shared serial units. A
   // finished result parks in DONE until the output register is free, so a
   // new request can be taken while the previous response is still stalled.
   typedef enum logic [7:0] {
      ST_IDLE    = 8'b0000_0001,
      ST_MUL     = 8'b0000_0010,
      ST_POW_SQ  = 8'b0000_0100,
      ST_POW_MUL = 8'b0000_1000,
      ST_MOD     = 8'b0001_0000,
      ST_SQR     = 8'b0010_0000,
      ST_INV     = 8'b0100_0000,
      ST_DONE    = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   // Only the low taps are kept: the x^48 term is always taken as present,
   // so the top bit of a write carries no information.
   logic [FIELD_BITS-1:0] taps_ff;

   logic [FIELD_BITS-1:0] a_ff, a_in;
   logic [FIELD_BITS-1:0] b_ff, b_in;
   logic [FIELD_BITS-1:0] exp_ff, exp_in;
   logic [FIELD_BITS-1:0] acc_ff, acc_in;
   logic [FIELD_BITS-1:0] res_ff, res_in;
   logic                  dz_ff, dz_in;
   logic [CNT_W-1:0]      bitcnt_ff, bitcnt_in;
   logic [CNT_W-1:0]      rmod_ff, rmod_in;
   logic                  go_ff, go_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   gf48_rsp_type          rsp_data_ff, rsp_data_in;

   logic                  accept;
   logic                  out_free;
   logic [CNT_W:0]        mod_sum;
   logic [CNT_W-1:0]      mod_next;

   logic                  mul_start, mul_done;
   logic [FIELD_BITS-1:0] mul_x, mul_y, mul_prod;
   logic                  inv_start, inv_done;
   logic [FIELD_BITS-1:0] inv_res;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Exponent mod 48, one exponent bit per cycle: the running remainder stays
   // below 48, so doubling plus one bit needs a single compare and subtract.
   assign mod_sum  = {rmod_ff, exp_ff[FIELD_BITS-1]};
   assign mod_next = (mod_sum >= (CNT_W+1)'(FIELD_BITS))
                     ? CNT_W'(mod_sum - (CNT_W+1)'(FIELD_BITS))
                     : mod_sum[CNT_W-1:0];

   // A launch is registered so that it follows the operand update.
   assign mul_start = go_ff && (state_ff != ST_INV);
   assign inv_start = go_ff && (state_ff == ST_INV);

   always_comb begin
      mul_x = acc_ff;
      mul_y = acc_ff;
      if (state_ff == ST_MUL) begin
         mul_x = a_ff;
         mul_y = b_ff;
      end else if (state_ff == ST_POW_MUL) begin
         mul_y = a_ff;
      end
   end

   gf48_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_x    (mul_x),
      .op_y    (mul_y),
      .taps    (taps_ff),
      .done    (mul_done),
      .product (mul_prod)
   );

   gf48_inv u_inv (
      .clock  (clock),
      .reset  (reset),
      .start  (inv_start),
      .op_x   (a_ff),
      .taps   (taps_ff),
      .done   (inv_done),
      .result (inv_res)
   );

   always_comb begin
      state_in     = state_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      exp_in       = exp_ff;
      acc_in       = acc_ff;
      res_in       = res_ff;
      dz_in        = dz_ff;
      bitcnt_in    = bitcnt_ff;
      rmod_in      = rmod_ff;
      go_in        = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               a_in      = req_data.operand_a;
               b_in      = req_data.operand_b;
               exp_in    = req_data.exponent;
               bitcnt_in = CNT_W'(FIELD_BITS);
               rmod_in   = '0;
               res_in    = '0;
               dz_in     = 1'b0;
               unique case (req_data.operation)
                  OP_ADD: begin
                     res_in   = req_data.operand_a ^ req_data.operand_b;
                     state_in = ST_DONE;
                  end
                  OP_MUL: begin
                     go_in    = 1'b1;
                     state_in = ST_MUL;
                  end
                  OP_INV: begin
                     if (req_data.operand_a == '0) begin
                        dz_in    = 1'b1;
                        state_in = ST_DONE;
                     end else begin
                        go_in    = 1'b1;
                        state_in = ST_INV;
                     end
                  end
                  OP_POW: begin
                     acc_in   = FIELD_BITS'(1);
                     go_in    = 1'b1;
                     state_in = ST_POW_SQ;
                  end
                  OP_SQR: begin
                     acc_in   = req_data.operand_a;
                     state_in = ST_MOD;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_MUL: begin
            if (mul_done) begin
               res_in   = mul_prod;
               state_in = ST_DONE;
            end
         end
         ST_POW_SQ: begin
            if (mul_done) begin
               acc_in = mul_prod;
               if (exp_ff[FIELD_BITS-1]) begin
                  go_in    = 1'b1;
                  state_in = ST_POW_MUL;
               end else if (bitcnt_ff == CNT_W'(1)) begin
                  res_in   = mul_prod;
                  state_in = ST_DONE;
               end else begin
                  exp_in    = {exp_ff[FIELD_BITS-2:0], 1'b0};
                  bitcnt_in = bitcnt_ff - CNT_W'(1);
                  go_in     = 1'b1;
               end
            end
         end
         ST_POW_MUL: begin
            if (mul_done) begin
               acc_in    = mul_prod;
               exp_in    = {exp_ff[FIELD_BITS-2:0], 1'b0};
               bitcnt_in = bitcnt_ff - CNT_W'(1);
               if (bitcnt_ff == CNT_W'(1)) begin
                  res_in   = mul_prod;
                  state_in = ST_DONE;
               end else begin
                  go_in    = 1'b1;
                  state_in = ST_POW_SQ;
               end
            end
         end
         ST_MOD: begin
            rmod_in   = mod_next;
            exp_in    = {exp_ff[FIELD_BITS-2:0], 1'b0};
            bitcnt_in = bitcnt_ff - CNT_W'(1);
            if (bitcnt_ff == CNT_W'(1)) begin
               if (mod_next == '0) begin
                  res_in   = acc_ff;
                  state_in = ST_DONE;
               end else begin
                  go_in    = 1'b1;
                  state_in = ST_SQR;
               end
            end
         end
         ST_SQR: begin
            if (mul_done) begin
               acc_in = mul_prod;
               if (rmod_ff == CNT_W'(1)) begin
                  res_in   = mul_prod;
                  state_in = ST_DONE;
               end else begin
                  rmod_in = rmod_ff - CNT_W'(1);
                  go_in   = 1'b1;
               end
            end
         end
         ST_INV: begin
            if (inv_done) begin
               res_in   = inv_res;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.result      = res_ff;
               rsp_data_in.div_by_zero = dz_ff;
               state_in                = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         go_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         bitcnt_ff    <= '0;
         rmod_ff      <= '0;
         taps_ff      <= POLY_RESET[FIELD_BITS-1:0];
      end else begin
         state_ff     <= state_in;
         go_ff        <= go_in;
         rsp_valid_ff <= rsp_valid_in;
         bitcnt_ff    <= bitcnt_in;
         rmod_ff      <= rmod_in;
         if (csr_wr_en) begin
            taps_ff <= csr_wr_data[FIELD_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff        <= a_in;
      b_ff        <= b_in;
      exp_ff      <= exp_in;
      acc_ff      <= acc_in;
      res_ff      <= res_in;
      dz_ff       <= dz_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A division-by-zero beat always carries a zero element.
   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.div_by_zero |-> rsp_data.result == '0)
      else $error("div_by_zero beat with nonzero result");

   // A new response beat only appears out of the DONE state.
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_DONE))
      else $error("response beat raised outside DONE");

   // The multiplier only finishes while the sequencer waits for it.
   a_mul_done_state: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == ST_MUL || state_ff == ST_POW_SQ ||
                    state_ff == ST_POW_MUL || state_ff == ST_SQR))
      else $error("multiplier finished with no waiting operation");

   // The inverter only finishes during an inverse operation.
   a_inv_done_state: assert property (@(posedge clock) disable iff (reset)
      inv_done |-> state_ff == ST_INV)
      else $error("inverter finished outside an inverse operation");

endmodule

/* hw/rtl/gf48_mul.sv */
// ----------------------------------------------------------------------------
// gf48_mul: bit-serial field multiplier
// Shift-and-add multiplication, one bit of the second operand per cycle from
// the most significant bit, with reduction by the polynomial taps.
// ----------------------------------------------------------------------------
module gf48_mul (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [gf48_pkg::FIELD_BITS-1:0] op_x,
   input  logic [gf48_pkg::FIELD_BITS-1:0] op_y,
   input  logic [gf48_pkg::FIELD_BITS-1:0] taps,
   output logic                            done,
   output logic [gf48_pkg::FIELD_BITS-1:0] product
);
   import gf48_pkg::*;

   logic [FIELD_BITS-1:0] acc_ff, acc_in;
   logic [FIELD_BITS-1:0] x_ff, x_in;
   logic [FIELD_BITS-1:0] y_ff, y_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;

   always_comb begin
      acc_in  = acc_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in  = '0;
         x_in    = op_x;
         y_in    = op_y;
         cnt_in  = CNT_W'(FIELD_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = {acc_ff[FIELD_BITS-2:0], 1'b0}
                  ^ (acc_ff[FIELD_BITS-1] ? taps : '0)
                  ^ (y_ff[FIELD_BITS-1] ? x_ff : '0);
         y_in   = {y_ff[FIELD_BITS-2:0], 1'b0};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

/* hw/rtl/gf48_inv.sv */
// ----------------------------------------------------------------------------
// gf48_inv: serial extended Euclid inverter
// Polynomial Euclid with coefficient tracking. Alignment shifts move one bit
// per cycle and degree searches step one bit position per cycle.
// ----------------------------------------------------------------------------
module gf48_inv (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [gf48_pkg::FIELD_BITS-1:0] op_x,
   input  logic [gf48_pkg::FIELD_BITS-1:0] taps,
   output logic                            done,
   output logic [gf48_pkg::FIELD_BITS-1:0] result
);
   import gf48_pkg::*;

   typedef enum logic [4:0] {
      IV_IDLE   = 5'b00001,
      IV_SEARCH = 5'b00010,
      IV_CHECK  = 5'b00100,
      IV_SHIFT  = 5'b01000,
      IV_FINAL  = 5'b10000
   } inv_state_type;

   inv_state_type state_ff, state_in;

   logic [POLY_W-1:0]     rem_ff, rem_in;
   logic [POLY_W-1:0]     cur_ff, cur_in;
   logic [POLY_W-1:0]     co_old_ff, co_old_in;
   logic [POLY_W-1:0]     co_cur_ff, co_cur_in;
   logic [POLY_W-1:0]     tmp_ff, tmp_in;
   logic [POLY_W-1:0]     tco_ff, tco_in;
   logic [LEN_W-1:0]      lr_ff, lr_in;
   logic [LEN_W-1:0]      la_ff, la_in;
   logic [LEN_W-1:0]      sh_ff, sh_in;
   logic [LEN_W-1:0]      srch_ff, srch_in;
   logic [ITER_W-1:0]     iter_ff, iter_in;
   logic [FIELD_BITS-1:0] res_ff, res_in;
   logic                  done_ff, done_in;

   logic [LEN_W-1:0]  srch_m1;
   logic [IDX_W-1:0]  srch_idx;
   logic [POLY_W-1:0] nrem;
   logic [POLY_W-1:0] nco;

   assign srch_m1  = srch_ff - LEN_W'(1);
   assign srch_idx = srch_m1[IDX_W-1:0];
   assign nrem     = rem_ff ^ tmp_ff;
   assign nco      = co_old_ff ^ tco_ff;

   always_comb begin
      state_in  = state_ff;
      rem_in    = rem_ff;
      cur_in    = cur_ff;
      co_old_in = co_old_ff;
      co_cur_in = co_cur_ff;
      tmp_in    = tmp_ff;
      tco_in    = tco_ff;
      lr_in     = lr_ff;
      la_in     = la_ff;
      sh_in     = sh_ff;
      srch_in   = srch_ff;
      iter_in   = iter_ff;
      res_in    = res_ff;
      done_in   = 1'b0;
      unique case (state_ff)
         IV_IDLE: begin
            if (start) begin
               rem_in    = {1'b1, taps};
               cur_in    = {1'b0, op_x};
               co_old_in = '0;
               co_cur_in = POLY_W'(1);
               lr_in     = LEN_W'(POLY_W);
               srch_in   = LEN_W'(FIELD_BITS);
               iter_in   = '0;
               state_in  = IV_SEARCH;
            end
         end
         IV_SEARCH: begin
            // Walk down from the highest possible bit to find the length.
            if (cur_ff[srch_idx] || srch_ff == LEN_W'(1)) begin
               la_in    = srch_ff;
               state_in = IV_CHECK;
            end else begin
               srch_in = srch_m1;
            end
         end
         IV_CHECK: begin
            if (iter_ff == ITER_W'(EUCLID_LIMIT) || cur_ff == '0) begin
               state_in = IV_FINAL;
            end else if (lr_ff >= la_ff) begin
               sh_in    = lr_ff - la_ff;
               tmp_in   = cur_ff;
               tco_in   = co_cur_ff;
               state_in = IV_SHIFT;
            end else begin
               // Remainder shorter than divisor: the pairs only trade places.
               rem_in    = cur_ff;
               cur_in    = rem_ff;
               lr_in     = la_ff;
               la_in     = lr_ff;
               co_old_in = co_cur_ff;
               co_cur_in = co_old_ff;
               iter_in   = iter_ff + ITER_W'(1);
            end
         end
         IV_SHIFT: begin
            if (sh_ff == '0) begin
               rem_in    = cur_ff;
               lr_in     = la_ff;
               co_old_in = co_cur_ff;
               cur_in    = nrem;
               co_cur_in = nco;
               iter_in   = iter_ff + ITER_W'(1);
               srch_in   = lr_ff - LEN_W'(1);
               state_in  = (nrem == '0) ? IV_CHECK : IV_SEARCH;
            end else begin
               tmp_in = {tmp_ff[POLY_W-2:0], 1'b0};
               tco_in = {tco_ff[POLY_W-2:0], 1'b0};
               sh_in  = sh_ff - LEN_W'(1);
            end
         end
         IV_FINAL: begin
            res_in   = co_old_ff[FIELD_BITS-1:0] ^ (co_old_ff[FIELD_BITS] ? taps : '0);
            done_in  = 1'b1;
            state_in = IV_IDLE;
         end
         default: begin
            state_in = IV_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IV_IDLE;
         done_ff  <= 1'b0;
         iter_ff  <= '0;
         sh_ff    <= '0;
         srch_ff  <= '0;
         lr_ff    <= '0;
         la_ff    <= '0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         iter_ff  <= iter_in;
         sh_ff    <= sh_in;
         srch_ff  <= srch_in;
         lr_ff    <= lr_in;
         la_ff    <= la_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff    <= rem_in;
      cur_ff    <= cur_in;
      co_old_ff <= co_old_in;
      co_cur_ff <= co_cur_in;
      tmp_ff    <= tmp_in;
      tco_ff    <= tco_in;
      res_ff    <= res_in;
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

/* sim/tb_gf2_48_arithmetic_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_gf2_48_arithmetic_unit: self-checking bench for the GF(2^48) unit
// Request beats come from a queue and go through a clocked driver. A clocked
// monitor compares each response beat with the oldest predicted field result.
// The polynomial register steps through several settings, among them the
// reducible reset value, a missing leading term and all taps set. Both
// channels idle in random bursts, except in some phases and in the last one.
// ----------------------------------------------------------------------------
module tb_gf2_48_arithmetic_unit;

   import gf48_pkg::*;

   // The unit leaves codes five to seven unused; they must answer with zero.
   localparam logic [2:0] OP_SPARE_LO  = 3'd5;
   localparam logic [2:0] OP_SPARE_MID = 3'd6;
   localparam logic [2:0] OP_SPARE_HI  = 3'd7;

   // One Euclid inverse may take 200 steps. The limit allows several times the
   // longest inverse, plus the longest stall and the longest gap.
   localparam int QUIET_LIMIT     = 100000;
   localparam int PHASE_COUNT     = 8;
   localparam int BEATS_PER_PHASE = 55;
   localparam int PRINT_LIMIT     = 40;

   logic                clock;
   logic                reset       = 1'b1;
   logic                req_valid   = 1'b0;
   logic                req_stall;
   gf48_req_type        req_data    = '0;
   logic                rsp_valid;
   logic                rsp_stall   = 1'b0;
   gf48_rsp_type        rsp_data;
   logic                csr_wr_en   = 1'b0;
   logic [POLY_W-1:0]   csr_wr_data = '0;

   // The bench's own copy of the polynomial register. It only changes while
   // no beat is in flight, so the driver can read it when it predicts.
   logic [POLY_W-1:0]   field_poly  = POLY_RESET;

   gf48_req_type        pending_requests[$];
   gf48_rsp_type        field_results[$];

   bit                  gaps_on     = 1'b1;
   int                  send_gap    = 0;
   int                  stall_left  = 0;
   int                  quiet_cycles = 0;
   int                  error_count = 0;

   gf2_48_arithmetic_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Field arithmetic of the prediction.
   // ------------------------------------------------------------------------

   // Shift-and-add product, most significant multiplier bit first. Bit 48 of
   // the polynomial is implied, so only the low 48 bits act as taps.
   function automatic logic [FIELD_BITS-1:0] mul_mod(input logic [FIELD_BITS-1:0] x,
                                                     input logic [FIELD_BITS-1:0] y,
                                                     input logic [POLY_W-1:0] poly);
      logic [FIELD_BITS-1:0] acc;
      logic                  carry;
      acc = '0;
      for (int k = FIELD_BITS - 1; k >= 0; k--) begin
         carry = acc[FIELD_BITS-1];
         acc   = {acc[FIELD_BITS-2:0], 1'b0};
         if (carry) begin
            acc ^= poly[FIELD_BITS-1:0];
         end
         if (y[k]) begin
            acc ^= x;
         end
      end
      return acc;
   endfunction

   // Number of bits up to the highest set one, never less than one.
   function automatic int used_bits(input logic [63:0] v);
      int n;
      n = 1;
      while (n < 64 && (v >> n) != 0) begin
         n++;
      end
      return n;
   endfunction

   // Polynomial Euclid with a bounded step count. For a reducible polynomial
   // the unit still returns whatever coefficient the last step left behind,
   // so the steps are followed exactly, with 64-bit working values.
   function automatic logic [FIELD_BITS-1:0] invert_elem(input logic [FIELD_BITS-1:0] x,
                                                         input logic [POLY_W-1:0] poly);
      logic [63:0] full_poly;
      logic [63:0] rem;
      logic [63:0] cur;
      logic [63:0] co_old;
      logic [63:0] co_cur;
      logic [63:0] nco;
      logic [63:0] nrem;
      int          la;
      int          lr;
      int          sh;
      full_poly = 64'(poly[FIELD_BITS-1:0]) | (64'd1 << FIELD_BITS);
      rem       = full_poly;
      cur       = 64'(x);
      co_old    = '0;
      co_cur    = 64'd1;
      for (int step = 0; step < EUCLID_LIMIT && cur != 0; step++) begin
         la   = used_bits(cur);
         lr   = used_bits(rem);
         nco  = co_old;
         nrem = rem;
         if (lr >= la) begin
            sh   = lr - la;
            nco  = co_old ^ (co_cur << sh);
            nrem = rem ^ (cur << sh);
         end
         co_old = co_cur;
         rem    = cur;
         co_cur = nco;
         cur    = nrem;
      end
      if (co_old[FIELD_BITS]) begin
         co_old ^= full_poly;
      end
      return co_old[FIELD_BITS-1:0];
   endfunction

   // Square-and-multiply over all 48 exponent bits, starting from one.
   function automatic logic [FIELD_BITS-1:0] raise_power(input logic [FIELD_BITS-1:0] base,
                                                         input logic [FIELD_BITS-1:0] e,
                                                         input logic [POLY_W-1:0] poly);
      logic [FIELD_BITS-1:0] acc;
      acc = FIELD_BITS'(1);
      for (int k = FIELD_BITS - 1; k >= 0; k--) begin
         acc = mul_mod(acc, acc, poly);
         if (e[k]) begin
            acc = mul_mod(acc, base, poly);
         end
      end
      return acc;
   endfunction

   // The squaring count wraps at the field width.
   function automatic logic [FIELD_BITS-1:0] square_times(input logic [FIELD_BITS-1:0] base,
                                                          input logic [FIELD_BITS-1:0] e,
                                                          input logic [POLY_W-1:0] poly);
      logic [FIELD_BITS-1:0] v;
      int                    count;
      v     = base;
      count = int'(e % FIELD_BITS'(FIELD_BITS));
      for (int k = 0; k < count; k++) begin
         v = mul_mod(v, v, poly);
      end
      return v;
   endfunction

   function automatic gf48_rsp_type compute_field_result(input gf48_req_type req,
                                                         input logic [POLY_W-1:0] poly);
      gf48_rsp_type rsp;
      rsp = '0;
      case (req.operation)
         OP_ADD: rsp.result = req.operand_a ^ req.operand_b;
         OP_MUL: rsp.result = mul_mod(req.operand_a, req.operand_b, poly);
         OP_INV: begin
            // Zero has no inverse: the result stays zero and the flag is set.
            if (req.operand_a == '0) begin
               rsp.div_by_zero = 1'b1;
            end else begin
               rsp.result = invert_elem(req.operand_a, poly);
            end
         end
         OP_POW: rsp.result = raise_power(req.operand_a, req.exponent, poly);
         OP_SQR: rsp.result = square_times(req.operand_a, req.exponent, poly);
         default: rsp = '0;
      endcase
      return rsp;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers.
   // ------------------------------------------------------------------------

   // Random element, weighted toward zero, all ones, one and single bits.
   function automatic logic [FIELD_BITS-1:0] random_element();
      logic [63:0] raw;
      raw = {$urandom(), $urandom()};
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return FIELD_BITS'(1);
         3: return FIELD_BITS'(1) << $urandom_range(0, FIELD_BITS - 1);
         default: return raw[FIELD_BITS-1:0];
      endcase
   endfunction

   task automatic queue_beat(input logic [2:0] op, input logic [FIELD_BITS-1:0] a,
                             input logic [FIELD_BITS-1:0] b, input logic [FIELD_BITS-1:0] e);
      gf48_req_type req;
      req.operation = op;
      req.operand_a = a;
      req.operand_b = b;
      req.exponent  = e;
      pending_requests.push_back(req);
   endtask

   // Returns once every queued beat has been sent and answered, after a short
   // pause for the unit to settle.
   task automatic wait_until_drained();
      do begin
         @(posedge clock);
      end while (pending_requests.size() != 0 || req_valid || field_results.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (error_count < PRINT_LIMIT) begin
         $display("%0t mismatch: %s got %h expected %h", $realtime, what, got, want);
      end
      error_count++;
   endtask

   // ------------------------------------------------------------------------
   // Request driver. An accepted beat is predicted right away, using the
   // polynomial that is in force. A beat that is not taken stays as it is;
   // otherwise the next one is either held back by a gap or taken from the
   // queue. Each output gets exactly one nonblocking assignment per edge.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : drive_requests
      gf48_req_type next_req;
      logic         next_valid;
      next_req   = req_data;
      next_valid = req_valid;
      if (reset) begin
         next_valid = 1'b0;
         send_gap   = 0;
      end else begin
         if (req_valid && !req_stall) begin
            field_results.push_back(compute_field_result(req_data, field_poly));
            next_valid = 1'b0;
         end
         if (!next_valid) begin
            if (send_gap != 0) begin
               send_gap--;
            end else if (pending_requests.size() != 0) begin
               if (gaps_on && $urandom_range(0, 3) == 0) begin
                  // This cycle is the first of the gap.
                  send_gap = $urandom_range(0, 18);
               end else begin
                  next_req   = pending_requests.pop_front();
                  next_valid = 1'b1;
               end
            end
         end
      end
      req_data  <= next_req;
      req_valid <= next_valid;
   end

   // ------------------------------------------------------------------------
   // Response monitor. Each accepted beat is checked field by field against
   // the oldest prediction. The stall input is raised in random bursts that
   // do not look at rsp_valid, so bursts land on every phase of the work.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : check_responses
      gf48_rsp_type want;
      logic         next_stall;
      next_stall = rsp_stall;
      if (reset) begin
         next_stall = 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (field_results.size() == 0) begin
               report_mismatch("response beat with nothing pending", 64'(rsp_data), '0);
            end else begin
               want = field_results.pop_front();
               if (rsp_data.result !== want.result) begin
                  report_mismatch("result", 64'(rsp_data.result), 64'(want.result));
               end
               if (rsp_data.div_by_zero !== want.div_by_zero) begin
                  report_mismatch("div_by_zero", 64'(rsp_data.div_by_zero),
                                  64'(want.div_by_zero));
               end
            end
         end
         if (stall_left != 0) begin
            stall_left--;
            next_stall = 1'b1;
         end else if (gaps_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 18);
            next_stall = 1'b1;
         end else begin
            next_stall = 1'b0;
         end
      end
      rsp_stall <= next_stall;
   end

   // Ends the run when neither channel has moved a beat for too long.
   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles == QUIET_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Sequence of the run: directed beats on the reset polynomial, then one
   // random phase per polynomial setting. The polynomial is only written
   // once everything sent before has been answered.
   // ------------------------------------------------------------------------
   initial begin : run_phases
      logic [POLY_W-1:0]     poly;
      logic [2:0]            op;
      logic [FIELD_BITS-1:0] all_ones;
      int                    pick;
      all_ones = '1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // The reset polynomial x^48 + 1 is reducible, so these beats also walk
      // the inverse through its bounded, non-field behavior.
      queue_beat(OP_ADD, '0, '0, '0);
      queue_beat(OP_ADD, all_ones, 48'h5555_5555_5555, all_ones);
      queue_beat(OP_ADD, 48'h8000_0000_0001, all_ones, '0);
      queue_beat(OP_MUL, all_ones, all_ones, '0);
      queue_beat(OP_MUL, '0, all_ones, all_ones);
      queue_beat(OP_MUL, 48'd1, 48'h8000_0000_0000, '0);
      queue_beat(OP_MUL, 48'h8000_0000_0000, 48'h8000_0000_0000, '0);
      queue_beat(OP_INV, '0, all_ones, all_ones);
      queue_beat(OP_INV, 48'd1, '0, '0);
      queue_beat(OP_INV, all_ones, '0, '0);
      queue_beat(OP_INV, 48'h8000_0000_0000, '0, '0);
      queue_beat(OP_INV, 48'd2, '0, '0);
      // A zero exponent gives one, even for a zero base.
      queue_beat(OP_POW, '0, '0, '0);
      queue_beat(OP_POW, all_ones, '0, all_ones);
      queue_beat(OP_POW, 48'd2, '0, 48'd1);
      queue_beat(OP_POW, '0, all_ones, 48'd5);
      // Squaring counts wrap at 48: 47 is the most, 48 means none.
      queue_beat(OP_SQR, 48'h1234_5678_9ABC, '0, '0);
      queue_beat(OP_SQR, 48'd2, '0, 48'd47);
      queue_beat(OP_SQR, 48'd2, '0, 48'd48);
      queue_beat(OP_SQR, all_ones, all_ones, all_ones);
      queue_beat(OP_SPARE_LO, all_ones, all_ones, all_ones);
      queue_beat(OP_SPARE_MID, 48'd1, 48'd1, 48'd1);
      queue_beat(OP_SPARE_HI, all_ones, '0, all_ones);

      for (int ph = 0; ph <= PHASE_COUNT; ph++) begin
         if (ph != 0) begin
            wait_until_drained();
            case (ph)
               1: poly = {1'b1, 48'h0000_0000_0291};
               2: poly = '0;                           // no leading term, no taps
               3: poly = '1;
               4: poly = {1'b0, all_ones};             // every tap, no leading term
               5: poly = {1'b1, 48'h0};                // leading term alone
               6: poly = {1'b1, random_element()};
               7: poly = {1'($urandom_range(0, 1)), random_element()};
               default: poly = {1'b1, 48'h0000_0000_0291};
            endcase
            @(posedge clock);
            csr_wr_en   <= 1'b1;
            csr_wr_data <= poly;
            field_poly   = poly;
            @(posedge clock);
            csr_wr_en   <= 1'b0;
         end
         // Some phases run with no idling at all, and so does the last one.
         gaps_on = (ph % 3 != 2) && (ph != PHASE_COUNT);
         for (int n = 0; n < BEATS_PER_PHASE; n++) begin
            // Inverse and power are the slow ones; keep them a minority.
            pick = $urandom_range(0, 99);
            if (pick < 20) begin
               op = OP_ADD;
            end else if (pick < 44) begin
               op = OP_MUL;
            end else if (pick < 58) begin
               op = OP_INV;
            end else if (pick < 70) begin
               op = OP_POW;
            end else if (pick < 88) begin
               op = OP_SQR;
            end else begin
               op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
            end
            queue_beat(op, random_element(), random_element(), random_element());
         end
      end

      wait_until_drained();
      repeat (64) @(posedge clock);
      if (field_results.size() != 0) begin
         report_mismatch("results never delivered", 64'(field_results.size()), '0);
      end
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

/* sim.f */
hw/rtl/gf48_pkg.sv
hw/rtl/gf48_mul.sv
hw/rtl/gf48_inv.sv
hw/rtl/gf2_48_arithmetic_unit.sv
sim/tb_gf2_48_arithmetic_unit.sv
